// ----- sv/dial_sweep_ratio_assert.svh -----
// Assertion macros used by the dial sweep ratio design.
`ifndef DIAL_SWEEP_RATIO_ASSERT_SVH
`define DIAL_SWEEP_RATIO_ASSERT_SVH

// Clocked check that is switched off while reset is asserted.
`define DSR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define DSR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/dsr_pkg.sv -----
`default_nettype none
package dsr_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int VEC_W = 17;
    localparam int PROD_W = 34;
    localparam int DOT_W = 35;
    localparam int CW = 38;
    localparam int ANG_W = 32;
    localparam int SWEEP_W = 33;
    localparam int SUM_W = 34;
    localparam int NUM_W = 45;
    localparam int REM_W = 49;
    localparam int Q_W = 16;
    localparam int DIV_STEPS = 16;
    localparam logic [ANG_W-1:0] HALF_TURN = 32'h8000_0000;

    typedef enum logic [2:0] {
        REG_START_X,
        REG_START_Y,
        REG_END_X,
        REG_END_Y,
        REG_CENTER_X,
        REG_CENTER_Y,
        REG_SWEEP_POS
    } reg_idx_t;

    typedef struct packed {
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic signed [15:0] end_x;
        logic signed [15:0] end_y;
        logic signed [15:0] center_x;
        logic signed [15:0] center_y;
    } dial_cfg_t;

    // Arctangent of 2^-i, one turn = 2^32.
    function automatic logic [ANG_W-1:0] atan_lut(input logic [4:0] idx);
        logic [ANG_W-1:0] r;
        case (idx)
            5'd0:  r = 32'h20000000;
            5'd1:  r = 32'h12E4051E;
            5'd2:  r = 32'h09FB385B;
            5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43;
            5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E;
            5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53;
            5'd9:  r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98;
            5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6;
            5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2FA;
            5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE;
            5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30;
            5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C;
            5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3;
            5'd23: r = 32'h00000051;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Turns a positive-direction angle into a sweep in the configured direction.
    function automatic logic [SWEEP_W-1:0] sweep_of(input logic [ANG_W-1:0] ang,
                                                    input logic pos);
        logic [SWEEP_W-1:0] r;
        if (pos)
            r = (ang == '0) ? {1'b1, {ANG_W{1'b0}}} : {1'b0, ang};
        else
            r = {1'b0, -ang};
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- sv/dsr_vec.sv -----
`default_nettype none
module dsr_vec (
    input  wire logic                             clk,
    input  wire logic                             en,
    input  wire dsr_pkg::dial_cfg_t               cfg,
    input  wire logic signed [15:0]               first_x,
    input  wire logic signed [15:0]               first_y,
    input  wire logic signed [15:0]               second_x,
    input  wire logic signed [15:0]               second_y,
    output logic signed [dsr_pkg::DOT_W-1:0]      dot [3],
    output logic signed [dsr_pkg::DOT_W-1:0]      crs [3],
    output logic                                  zero
);

    // Lane 0 is the end mark, lane 1 the first point, lane 2 the second point.
    logic signed [dsr_pkg::VEC_W-1:0]  a_x_reg, a_y_reg;
    logic signed [dsr_pkg::VEC_W-1:0]  b_x_reg [3];
    logic signed [dsr_pkg::VEC_W-1:0]  b_y_reg [3];
    logic signed [dsr_pkg::PROD_W-1:0] pp_reg [3][4];
    logic signed [dsr_pkg::DOT_W-1:0]  dot_reg [3];
    logic signed [dsr_pkg::DOT_W-1:0]  crs_reg [3];
    logic                              zero1_reg, zero2_reg, zero3_reg;

    logic signed [dsr_pkg::VEC_W-1:0]  a_x_next, a_y_next;
    logic signed [dsr_pkg::VEC_W-1:0]  b_x_next [3];
    logic signed [dsr_pkg::VEC_W-1:0]  b_y_next [3];
    logic                              zero1_next;

    function automatic logic signed [dsr_pkg::VEC_W-1:0] diff(input logic signed [15:0] p,
                                                             input logic signed [15:0] c);
        return $signed({p[15], p}) - $signed({c[15], c});
    endfunction

    function automatic logic signed [dsr_pkg::DOT_W-1:0] DOT_W_EXT(
        input logic signed [dsr_pkg::PROD_W-1:0] v);
        return {v[dsr_pkg::PROD_W-1], v};
    endfunction

    always_comb
    begin
        a_x_next    = diff(cfg.start_x, cfg.center_x);
        a_y_next    = diff(cfg.start_y, cfg.center_y);
        b_x_next[0] = diff(cfg.end_x, cfg.center_x);
        b_y_next[0] = diff(cfg.end_y, cfg.center_y);
        b_x_next[1] = diff(first_x, cfg.center_x);
        b_y_next[1] = diff(first_y, cfg.center_y);
        b_x_next[2] = diff(second_x, cfg.center_x);
        b_y_next[2] = diff(second_y, cfg.center_y);
        zero1_next  = (a_x_next == '0 && a_y_next == '0)
                   || (b_x_next[0] == '0 && b_y_next[0] == '0)
                   || (b_x_next[1] == '0 && b_y_next[1] == '0)
                   || (b_x_next[2] == '0 && b_y_next[2] == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_x_reg   <= a_x_next;
            a_y_reg   <= a_y_next;
            zero1_reg <= zero1_next;
            zero2_reg <= zero1_reg;
            zero3_reg <= zero2_reg;
            for (int l = 0; l < 3; l++)
            begin
                b_x_reg[l]   <= b_x_next[l];
                b_y_reg[l]   <= b_y_next[l];
                pp_reg[l][0] <= a_x_reg * b_x_reg[l];
                pp_reg[l][1] <= a_y_reg * b_y_reg[l];
                pp_reg[l][2] <= a_x_reg * b_y_reg[l];
                pp_reg[l][3] <= a_y_reg * b_x_reg[l];
                dot_reg[l]   <= DOT_W_EXT(pp_reg[l][0]) + DOT_W_EXT(pp_reg[l][1]);
                crs_reg[l]   <= DOT_W_EXT(pp_reg[l][2]) - DOT_W_EXT(pp_reg[l][3]);
            end
        end
    end

    assign dot  = dot_reg;
    assign crs  = crs_reg;
    assign zero = zero3_reg;

endmodule
`default_nettype wire

// ----- sv/dsr_cordic.sv -----
`default_nettype none
module dsr_cordic (
    input  wire logic                             clk,
    input  wire logic                             en,
    input  wire logic signed [dsr_pkg::DOT_W-1:0] dot,
    input  wire logic signed [dsr_pkg::DOT_W-1:0] crs,
    output logic [dsr_pkg::ANG_W-1:0]             angle
);

    localparam int N = dsr_pkg::CORDIC_STAGES;
    localparam int W = dsr_pkg::CW;

    logic signed [W-1:0]              x_reg [N+1];
    logic signed [W-1:0]              y_reg [N+1];
    logic [dsr_pkg::ANG_W-1:0]        z_reg [N+1];
    logic                             col_reg [N+1];

    logic signed [W-1:0]              x0_next, y0_next;
    logic [dsr_pkg::ANG_W-1:0]        z0_next;

    // A negative dot product is turned by a half turn first, so the rotation
    // only ever has to cover the right half plane.
    always_comb
    begin
        x0_next = W'(dot);
        y0_next = W'(crs);
        z0_next = '0;
        if (dot < 0)
        begin
            x0_next = -x0_next;
            y0_next = -y0_next;
            z0_next = dsr_pkg::HALF_TURN;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]   <= x0_next;
            y_reg[0]   <= y0_next;
            z_reg[0]   <= z0_next;
            col_reg[0] <= (crs == '0);
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        logic signed [W-1:0] xs, ys;
        assign xs = x_reg[i] >>> i;
        assign ys = y_reg[i] >>> i;

        // Collinear vectors keep their angle of zero or a half turn.
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                col_reg[i+1] <= col_reg[i];
                if (y_reg[i] > 0)
                begin
                    x_reg[i+1] <= x_reg[i] + ys;
                    y_reg[i+1] <= y_reg[i] - xs;
                    z_reg[i+1] <= col_reg[i] ? z_reg[i] : z_reg[i] + dsr_pkg::atan_lut(5'(i));
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - ys;
                    y_reg[i+1] <= y_reg[i] + xs;
                    z_reg[i+1] <= col_reg[i] ? z_reg[i] : z_reg[i] - dsr_pkg::atan_lut(5'(i));
                end
            end
        end
    end

    assign angle = z_reg[N];

endmodule
`default_nettype wire

// ----- sv/dsr_div.sv -----
`default_nettype none
module dsr_div (
    input  wire logic                               clk,
    input  wire logic                               en,
    input  wire logic [dsr_pkg::NUM_W-1:0]          num,
    input  wire logic [dsr_pkg::SWEEP_W-1:0]        den,
    output logic [dsr_pkg::Q_W-1:0]                 ratio
);

    localparam int S = dsr_pkg::DIV_STEPS;
    localparam int RW = dsr_pkg::REM_W;

    logic [RW-1:0]                   rem_reg [S+1];
    logic [dsr_pkg::SWEEP_W-1:0]     den_reg [S+1];
    logic [dsr_pkg::Q_W-1:0]         q_reg   [S+1];
    logic                            sat_reg [S+1];

    // Quotients of 2^16 or more saturate; below that the remainder always
    // stays under the divisor shifted by the next quotient bit.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= RW'(num);
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            sat_reg[0] <= (RW'(num) >= {den, 16'b0});
        end
    end

    for (genvar j = 0; j < S; j++)
    begin : g_step
        localparam int K = S - 1 - j;
        logic [RW-1:0] trial;
        logic          geq;
        assign trial = RW'(den_reg[j]) << K;
        assign geq   = rem_reg[j] >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j+1] <= geq ? rem_reg[j] - trial : rem_reg[j];
                den_reg[j+1] <= den_reg[j];
                sat_reg[j+1] <= sat_reg[j];
                q_reg[j+1]   <= q_reg[j] | (dsr_pkg::Q_W'(geq) << K);
            end
        end
    end

    assign ratio = sat_reg[S] ? '1 : q_reg[S];

endmodule
`default_nettype wire

// ----- sv/dial_sweep_ratio.sv -----
// Pipeline: 3 vector/product stages, the CORDIC, 1 sweep stage and 17 divider stages lie
// between an accepted input word and its result word.
// Throughput: one word per cycle; the whole pipeline advances together and halts only
// while the output register holds a word that is not taken.
// Reset: rst_n is asynchronous, active low; it clears all configuration registers to 0
// and empties the pipeline. There is no clearing pass.
`default_nettype none
`include "dial_sweep_ratio_assert.svh"
module dial_sweep_ratio (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // Input words.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // first_x, first_y, second_x, second_y
    // Result words.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // ratio
    output logic [0:0]       m_axis_tuser    // invalid
);

    localparam int N   = dsr_pkg::CORDIC_STAGES;
    localparam int LAT = N + 22;
    localparam int DQ  = dsr_pkg::DIV_STEPS + 1;

    // Configuration registers.
    dsr_pkg::dial_cfg_t cfg_reg;
    logic               pos_reg;
    logic               wr_en;
    dsr_pkg::reg_idx_t  wr_idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign wr_idx = dsr_pkg::reg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
            pos_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            case (wr_idx)
                dsr_pkg::REG_START_X:   cfg_reg.start_x  <= pwdata[15:0];
                dsr_pkg::REG_START_Y:   cfg_reg.start_y  <= pwdata[15:0];
                dsr_pkg::REG_END_X:     cfg_reg.end_x    <= pwdata[15:0];
                dsr_pkg::REG_END_Y:     cfg_reg.end_y    <= pwdata[15:0];
                dsr_pkg::REG_CENTER_X:  cfg_reg.center_x <= pwdata[15:0];
                dsr_pkg::REG_CENTER_Y:  cfg_reg.center_y <= pwdata[15:0];
                dsr_pkg::REG_SWEEP_POS: pos_reg          <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Readback sign-extends the coordinates to the bus width.
    always_comb
    begin
        case (wr_idx)
            dsr_pkg::REG_START_X:   prdata = 32'(cfg_reg.start_x);
            dsr_pkg::REG_START_Y:   prdata = 32'(cfg_reg.start_y);
            dsr_pkg::REG_END_X:     prdata = 32'(cfg_reg.end_x);
            dsr_pkg::REG_END_Y:     prdata = 32'(cfg_reg.end_y);
            dsr_pkg::REG_CENTER_X:  prdata = 32'(cfg_reg.center_x);
            dsr_pkg::REG_CENTER_Y:  prdata = 32'(cfg_reg.center_y);
            dsr_pkg::REG_SWEEP_POS: prdata = {31'b0, pos_reg};
            default:                prdata = '0;
        endcase
    end

    // One enable moves every stage. A bubble anywhere is overwritten by the
    // next stage's move, so a word only waits while the output is blocked.
    logic vld_reg [LAT];
    logic en;

    assign en            = !vld_reg[LAT-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LAT; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= s_axis_tvalid;
            for (int k = 1; k < LAT; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    // Differences from the centre, then dot and cross products per lane.
    logic signed [dsr_pkg::DOT_W-1:0] dot [3];
    logic signed [dsr_pkg::DOT_W-1:0] crs [3];
    logic                             zero;

    dsr_vec u_vec (
        .clk      (clk),
        .en       (en),
        .cfg      (cfg_reg),
        .first_x  (s_axis_tdata[15:0]),
        .first_y  (s_axis_tdata[31:16]),
        .second_x (s_axis_tdata[47:32]),
        .second_y (s_axis_tdata[63:48]),
        .dot      (dot),
        .crs      (crs),
        .zero     (zero)
    );

    // Three angle lanes: end mark, first point, second point.
    logic [dsr_pkg::ANG_W-1:0] angle [3];

    for (genvar l = 0; l < 3; l++)
    begin : g_lane
        dsr_cordic u_cordic (
            .clk   (clk),
            .en    (en),
            .dot   (dot[l]),
            .crs   (crs[l]),
            .angle (angle[l])
        );
    end

    // The zero-length flag rides alongside the CORDIC.
    logic bad_c_reg [N+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bad_c_reg[0] <= zero;
            for (int k = 1; k <= N; k++)
                bad_c_reg[k] <= bad_c_reg[k-1];
        end
    end

    // Sweep stage: angles become sweeps, and a bad word is replaced by a
    // division of zero by one so that the divider yields a ratio of zero.
    logic [dsr_pkg::SWEEP_W-1:0] se, s1, s2;
    logic [dsr_pkg::SUM_W-1:0]   ssum;
    logic                        sw_bad_next;
    logic [dsr_pkg::NUM_W-1:0]   sw_num_reg;
    logic [dsr_pkg::SWEEP_W-1:0] sw_den_reg;
    logic                        sw_bad_reg;

    always_comb
    begin
        se          = dsr_pkg::sweep_of(angle[0], pos_reg);
        s1          = dsr_pkg::sweep_of(angle[1], pos_reg);
        s2          = dsr_pkg::sweep_of(angle[2], pos_reg);
        ssum        = dsr_pkg::SUM_W'(s1) + dsr_pkg::SUM_W'(s2);
        sw_bad_next = bad_c_reg[N] || (se == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sw_bad_reg <= sw_bad_next;
            sw_num_reg <= sw_bad_next ? '0 : {ssum, 11'b0};
            sw_den_reg <= sw_bad_next ? dsr_pkg::SWEEP_W'(1) : se;
        end
    end

    // Divider, one quotient bit per stage after the saturation check.
    logic [dsr_pkg::Q_W-1:0] ratio;

    dsr_div u_div (
        .clk   (clk),
        .en    (en),
        .num   (sw_num_reg),
        .den   (sw_den_reg),
        .ratio (ratio)
    );

    logic bad_d_reg [DQ];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bad_d_reg[0] <= sw_bad_reg;
            for (int k = 1; k < DQ; k++)
                bad_d_reg[k] <= bad_d_reg[k-1];
        end
    end

    assign m_axis_tdata    = ratio;
    assign m_axis_tuser[0] = bad_d_reg[DQ-1];

    // A flagged word always carries a ratio of zero.
    `DSR_ASSERT(a_invalid_zero, (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0),
                "invalid word with nonzero ratio")
    // The divider never sees a zero divisor for a live word.
    `DSR_ASSERT(a_den_nonzero, vld_reg[N+4] |-> (sw_den_reg != '0),
                "zero divisor entered the divider")
    // A stalled pipeline holds the divider inputs.
    `DSR_ASSERT(a_stall_hold, !en |=> ($stable(sw_num_reg) && $stable(sw_den_reg)),
                "divider inputs changed during a stall")
    // Once reset is asserted the pipeline is empty.
    `DSR_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !m_axis_tvalid,
                       "output valid during reset")

endmodule
`default_nettype wire
